/* rtl/core/rmvt_pkg.sv */
// Package for the running mean and variance tracker.
// Widths, defaults, the controller state type, lane status and payload structs.
package rmvt_pkg;
   localparam int NumMetricsDefault = 7;
   localparam int FracBitsDefault   = 16;
   localparam int ValueBitsDefault  = 32;
   localparam int InputMetrics      = 7;
   localparam int CountBits         = 32;
   localparam int MeanBits          = 48;
   localparam int SumBits           = 64;
   localparam int StdBits           = 32;
   localparam int IndexBits         = 3;
   localparam logic [31:0] MinSamplesReset = 32'd300;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EMIT
   } ctrl_state_type;

   // Lane status seen by the controller.
   typedef struct packed {
      logic busy;
      logic done;
   } lane_status_type;

   typedef struct packed {
      logic [IndexBits-1:0] metric_index;
      logic [CountBits-1:0] sample_count;
      logic [MeanBits-1:0]  mean_value;
      logic [SumBits-1:0]   variance_value;
      logic [StdBits-1:0]   std_dev;
      logic                 ready_res;
      logic                 last;
   } rsp_payload_type;
endpackage

/* rtl/core/rmvt_if.sv */
// Channel interfaces for the running mean and variance tracker.
// Depends on rmvt_pkg for the result payload type.
interface rmvt_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [6:0]  valid_mask;
   logic [31:0] crypto_instr_rate;
   logic [31:0] cycle_rate;
   logic [31:0] miss_rate;
   logic [31:0] modify_rate;
   logic [31:0] rename_rate;
   logic [31:0] delete_rate;
   logic [31:0] disk_write_rate;
   modport source (output valid, kind, valid_mask, crypto_instr_rate, cycle_rate, miss_rate,
                   modify_rate, rename_rate, delete_rate, disk_write_rate, input ready);
   modport sink (input valid, kind, valid_mask, crypto_instr_rate, cycle_rate, miss_rate,
                 modify_rate, rename_rate, delete_rate, disk_write_rate, output ready);
endinterface

interface rmvt_rsp_if;
   import rmvt_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, payload, input ready);
   modport sink (input valid, payload, output ready);
endinterface

/* rtl/core/rmvt_lane.sv */
// One metric lane: Welford update with a serial divider for the mean step and a
// shift-and-add multiplier for the M2 step. Depends on rmvt_pkg.
module rmvt_lane #(
   parameter int FRAC_BITS  = rmvt_pkg::FracBitsDefault,
   parameter int VALUE_BITS = rmvt_pkg::ValueBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               clear,
   input  logic [VALUE_BITS-1:0]              value,
   output rmvt_pkg::lane_status_type          status,
   output logic [rmvt_pkg::CountBits-1:0]     count_out,
   output logic [rmvt_pkg::MeanBits-1:0]      mean_out,
   output logic [rmvt_pkg::SumBits-1:0]       sum_out
);
   import rmvt_pkg::*;
   localparam int DivSteps = 64;
   localparam int StepBits = $clog2(DivSteps + 3);
   localparam logic [StepBits-1:0] StepLast = StepBits'(DivSteps - 1);
   localparam logic [StepBits-1:0] StepProd = StepBits'(DivSteps);

   logic [CountBits-1:0] count_ff, count_in;
   logic [MeanBits-1:0]  mean_ff, mean_in;
   logic [SumBits-1:0]   sum_ff, sum_in;
   logic [63:0]          x_ff, x_in;
   logic [63:0]          ad1_ff, ad1_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          quo_ff, quo_in;
   logic [64:0]          rem_ff, rem_in;
   logic [StepBits-1:0]  step_ff, step_in;
   logic [1:0]           phase_ff, phase_in;
   logic [63:0]          prod_ff, prod_in;
   logic                 sat_ff, sat_in;
   logic [127:0]         full_ff, full_in;
   logic [127:0]         mcand_ff, mcand_in;

   logic [64:0] rem_sh;
   logic [64:0] trial;
   logic [63:0] m_new;
   logic [63:0] d1;
   logic [63:0] d2;
   logic [63:0] ad2;
   logic [64:0] acc;

   assign status.busy = (phase_ff != 2'd0);
   assign status.done = (phase_ff == 2'd3);
   assign count_out = count_ff;
   assign mean_out  = mean_ff;
   assign sum_out   = sum_ff;

   // Datapath: signed deviation, restoring divider one bit a cycle, then a
   // shift-and-add product of the two deviations and the M2 update.
   always_comb begin
      count_in = count_ff;
      mean_in  = mean_ff;
      sum_in   = sum_ff;
      x_in     = x_ff;
      ad1_in   = ad1_ff;
      neg_in   = neg_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      phase_in = phase_ff;
      prod_in  = prod_ff;
      sat_in   = sat_ff;
      full_in  = full_ff;
      mcand_in = mcand_ff;
      d1 = (64'(value) << FRAC_BITS) - 64'(mean_ff);
      rem_sh = {rem_ff[63:0], ad1_ff[6'd63 - step_ff[5:0]]};
      trial  = rem_sh - {33'd0, count_ff};
      m_new  = neg_ff ? (64'(mean_ff) - quo_ff) : (64'(mean_ff) + quo_ff);
      d2     = x_ff - m_new;
      ad2    = d2[63] ? (64'd0 - d2) : d2;
      acc    = 65'(sum_ff) + 65'(prod_ff);
      if (clear) begin
         count_in = '0;
         mean_in  = '0;
         sum_in   = '0;
         phase_in = 2'd0;
      end else begin
         unique case (phase_ff)
            2'd0: begin
               if (start) begin
                  x_in     = 64'(value) << FRAC_BITS;
                  neg_in   = d1[63];
                  ad1_in   = d1[63] ? (64'd0 - d1) : d1;
                  count_in = (count_ff == '1) ? count_ff : count_ff + 1'b1;
                  quo_in   = '0;
                  rem_in   = '0;
                  step_in  = '0;
                  phase_in = 2'd1;
               end
            end
            2'd1: begin
               if (!trial[64]) begin
                  rem_in = trial;
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == StepLast) phase_in = 2'd2;
            end
            2'd2: begin
               mean_in  = m_new[MeanBits-1:0];
               full_in  = '0;
               mcand_in = {64'd0, ad2};
               phase_in = 2'd3;
               step_in  = '0;
            end
            default: begin
               // One multiplier bit a cycle, then scale the product, then accumulate.
               if (step_ff < StepProd) begin
                  if (ad1_ff[0]) full_in = full_ff + mcand_ff;
                  mcand_in = {mcand_ff[126:0], 1'b0};
                  ad1_in   = {1'b0, ad1_ff[63:1]};
                  step_in  = step_ff + 1'b1;
               end else if (step_ff == StepProd) begin
                  prod_in = full_ff[2*FRAC_BITS +: 64];
                  sat_in  = (full_ff >> (2*FRAC_BITS + 64)) != '0;
                  step_in = step_ff + 1'b1;
               end else begin
                  sum_in   = (sat_ff || acc[64]) ? '1 : acc[63:0];
                  phase_in = 2'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mean_ff  <= '0;
         sum_ff   <= '0;
         phase_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         mean_ff  <= mean_in;
         sum_ff   <= sum_in;
         phase_ff <= phase_in;
      end
      x_ff     <= x_in;
      ad1_ff   <= ad1_in;
      neg_ff   <= neg_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      prod_ff  <= prod_in;
      sat_ff   <= sat_in;
      full_ff  <= full_in;
      mcand_ff <= mcand_in;
   end
endmodule

/* rtl/core/rmvt_merge.sv */
// Merging stage: per metric, serial variance division and square root, then the beat.
// Depends on rmvt_pkg.
module rmvt_merge #(
   parameter int NUM_METRICS = rmvt_pkg::NumMetricsDefault
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  logic [NUM_METRICS-1:0][rmvt_pkg::CountBits-1:0] counts,
   input  logic [NUM_METRICS-1:0][rmvt_pkg::MeanBits-1:0]  means,
   input  logic [NUM_METRICS-1:0][rmvt_pkg::SumBits-1:0]   sums,
   input  logic [31:0]                             min_samples,
   output logic                                    busy,
   rmvt_rsp_if.source                              rsp
);
   import rmvt_pkg::*;
   localparam int MetBits = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;

   logic [MetBits-1:0] met_ff, met_in;
   logic [1:0]  phase_ff, phase_in;
   logic [6:0]  step_ff, step_in;
   logic        ready_ff, ready_in;
   logic [63:0] num_ff, num_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] sv_ff, sv_in;
   logic [63:0] sres_ff, sres_in;
   logic [63:0] sbit_ff, sbit_in;
   logic        vld_ff, vld_in;
   rsp_payload_type pay_ff, pay_in;

   logic [CountBits-1:0] cnt;
   logic [64:0] rem_sh, trial;
   logic [64:0] sq_try;
   logic        all_ready;

   assign busy = (phase_ff != 2'd0) || vld_ff;
   assign rsp.valid   = vld_ff;
   assign rsp.payload = pay_ff;
   assign cnt = counts[met_ff];

   // Ready flag over every lane count.
   always_comb begin
      all_ready = 1'b1;
      for (int i = 0; i < NUM_METRICS; i++)
         if (counts[i] < min_samples) all_ready = 1'b0;
   end

   always_comb begin
      met_in = met_ff; phase_in = phase_ff; step_in = step_ff; ready_in = ready_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff;
      sv_in = sv_ff; sres_in = sres_ff; sbit_in = sbit_ff;
      vld_in = vld_ff; pay_in = pay_ff;
      rem_sh = {rem_ff[63:0], num_ff[6'd63 - step_ff[5:0]]};
      trial  = rem_sh - {33'd0, cnt - 32'd1};
      sq_try = {1'b0, sv_ff} - {1'b0, sres_ff + sbit_ff};
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      unique case (phase_ff)
         2'd0: begin
            if (start) begin
               met_in = '0; ready_in = all_ready; phase_in = 2'd1;
               num_in = sums[0]; rem_in = '0; quo_in = '0; step_in = '0;
            end
         end
         2'd1: begin
            // Variance: M2 over count minus one, one quotient bit a cycle.
            if (cnt <= 32'd1) begin
               sv_in = '0; sres_in = '0; sbit_in = 64'd1 << 62; phase_in = 2'd2;
            end else begin
               if (!trial[64]) begin
                  rem_in = trial; quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = rem_sh; quo_in = {quo_ff[62:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 7'd63) begin
                  sv_in = !trial[64] ? {quo_ff[62:0], 1'b1} : {quo_ff[62:0], 1'b0};
                  sres_in = '0; sbit_in = 64'd1 << 62; phase_in = 2'd2;
               end
            end
         end
         2'd2: begin
            // Square root of the variance, digit by digit.
            if (sbit_ff == '0) begin
               phase_in = 2'd3;
            end else begin
               if (!sq_try[64]) begin
                  sv_in = sq_try[63:0]; sres_in = (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_in = sres_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end
         end
         default: begin
            // The quotient register still holds the variance; load the beat.
            if (!vld_ff || rsp.ready) begin
               vld_in = 1'b1;
               pay_in.metric_index   = IndexBits'(met_ff);
               pay_in.sample_count   = cnt;
               pay_in.mean_value     = means[met_ff];
               pay_in.variance_value = quo_ff;
               pay_in.std_dev        = sres_ff[StdBits-1:0];
               pay_in.ready_res      = ready_ff;
               pay_in.last           = (met_ff == MetBits'(NUM_METRICS - 1));
               if (met_ff == MetBits'(NUM_METRICS - 1)) begin
                  phase_in = 2'd0;
               end else begin
                  met_in = met_ff + 1'b1; phase_in = 2'd1;
                  num_in = sums[met_ff + 1'b1]; rem_in = '0; quo_in = '0; step_in = '0;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 2'd0;
         vld_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         vld_ff   <= vld_in;
      end
      met_ff <= met_in; step_ff <= step_in; ready_ff <= ready_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in;
      sv_ff <= sv_in; sres_ff <= sres_in; sbit_ff <= sbit_in; pay_ff <= pay_in;
   end
endmodule

/* rtl/core/running_mean_variance_tracker_core.sv */
// Top level of the running mean and variance tracker.
// Depends on rmvt_pkg, rmvt_if, rmvt_lane and rmvt_merge.

// Keeps Welford statistics for the telemetry metrics in parallel lanes. A request beat is
// taken only when the block is idle and its last result beat has been taken. The lanes
// update together: the bit-serial mean divider, the new mean, then the shift-and-add
// product of the deviations and the M2 accumulation; the controller then hands over to
// the merging stage. For each metric the merging stage runs the bit-serial variance
// divider, the square root and the load of the beat, and skips the divider when the
// count is at most one. The result beats can be held by stalls on the result channel,
// and the next request is taken only after the last result beat has been taken.
// A clear beat skips the lanes, so the merging stage starts without a lane update.
module running_mean_variance_tracker_core #(
   parameter int NUM_METRICS = rmvt_pkg::NumMetricsDefault,
   parameter int FRAC_BITS   = rmvt_pkg::FracBitsDefault,
   parameter int VALUE_BITS  = rmvt_pkg::ValueBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   rmvt_req_if.sink    req,
   rmvt_rsp_if.source  rsp
);
   import rmvt_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [31:0] min_samples_ff;
   logic [NUM_METRICS-1:0] lane_start, lane_busy;
   lane_status_type lane_status [NUM_METRICS];
   logic [NUM_METRICS-1:0][CountBits-1:0] counts;
   logic [NUM_METRICS-1:0][MeanBits-1:0]  means;
   logic [NUM_METRICS-1:0][SumBits-1:0]   sums;
   logic [InputMetrics-1:0][31:0] values;
   logic accept, clear, merge_start, merge_busy;

   assign values = {req.disk_write_rate, req.delete_rate, req.rename_rate, req.modify_rate,
                    req.miss_rate, req.cycle_rate, req.crypto_instr_rate};
   assign req.ready = (state_ff == ST_IDLE) && !merge_busy;
   assign accept = req.valid && req.ready;
   assign clear  = accept && (req.kind == KIND_CLEAR);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) min_samples_ff <= MinSamplesReset;
      else if (csr_write_enable) min_samples_ff <= csr_write_data;
   end

   // One lane per metric with an input field; the other metrics are tied to zero and never start.
   for (genvar i = 0; i < NUM_METRICS; i++) begin : g_lane
      if (i < InputMetrics) begin : g_in
         assign lane_start[i] = accept && (req.kind == KIND_SAMPLE) && req.valid_mask[i];
         rmvt_lane #(.FRAC_BITS(FRAC_BITS), .VALUE_BITS(VALUE_BITS)) u_lane (
            .clock(clock), .reset(reset), .start(lane_start[i]), .clear(clear),
            .value(values[i][VALUE_BITS-1:0]), .status(lane_status[i]),
            .count_out(counts[i]), .mean_out(means[i]), .sum_out(sums[i]));
      end else begin : g_none
         assign lane_start[i] = 1'b0;
         assign lane_status[i] = '0;
         assign counts[i] = '0;
         assign means[i]  = '0;
         assign sums[i]   = '0;
      end
      assign lane_busy[i] = lane_status[i].busy;
   end

   // Controller: wait for every lane, then hand over to the merging stage.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      merge_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (lane_busy == '0) begin
               merge_start = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   rmvt_merge #(.NUM_METRICS(NUM_METRICS)) u_merge (
      .clock(clock), .reset(reset), .start(merge_start), .counts(counts), .means(means),
      .sums(sums), .min_samples(min_samples_ff), .busy(merge_busy), .rsp(rsp));
endmodule
